// ===== sv/erc_pkg.sv =====
// Shared types and constants for the event rate counter bank.
// Used by the channel interfaces, the counter memory, the divider and the top level.
// No dependencies.
package erc_pkg;

  // Number of counters in the bank and the address width of one counter row.
  localparam int COUNTERS = 64;
  localparam int CNT_AW   = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;

  // Payload widths fixed by the item format.
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 6;
  localparam int RUN_W  = 32;
  localparam int TOT_W  = 64;
  localparam int SEC_W  = 32;
  localparam int CIU_W  = 7;

  // Width of the divider step counter, one step per quotient bit.
  localparam int DIV_STEP_W = $clog2(TOT_W);

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CIU_W-1:0] CIU_RESET = 7'd64;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_COUNTERS_IN_USE = 1'b0
  } reg_index_t;

  // Item action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_COUNT = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TRD,
    S_TWR,
    S_DIV,
    S_OUT
  } state_t;

  // One counter row as stored in the bank memory.
  typedef struct packed {
    logic [RUN_W-1:0] running;
    logic [RUN_W-1:0] last;
    logic [TOT_W-1:0] total;
  } row_t;

  // Write request into the bank memory.
  typedef struct packed {
    logic              en;
    logic [CNT_AW-1:0] addr;
    row_t              row;
  } mem_wr_t;

  // Read request into the bank memory.
  typedef struct packed {
    logic              en;
    logic [CNT_AW-1:0] addr;
  } mem_rd_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/erc_if.sv =====
// Valid/ready channel interfaces for the event rate counter bank.
// Depends on erc_pkg for field widths.
interface erc_in_if;
  import erc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] counter_index;

  modport source (output valid, output action, output counter_index, input ready);
  modport sink   (input valid, input action, input counter_index, output ready);
endinterface

interface erc_out_if;
  import erc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] last_second_count;
  logic [TOT_W-1:0] total_count;
  logic [TOT_W-1:0] avg_per_sec;
  logic             bad_index;

  modport source (output valid, output last_second_count, output total_count,
                  output avg_per_sec, output bad_index, input ready);
  modport sink   (input valid, input last_second_count, input total_count,
                  input avg_per_sec, input bad_index, output ready);
endinterface

// ===== sv/erc_row_mem.sv =====
// Counter bank memory: one row per counter with running, last and total counts.
// Per-row valid bits make rows read as zero until first written after reset.
// Depends on erc_pkg.
module erc_row_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  erc_pkg::mem_wr_t wr,
  input  erc_pkg::mem_rd_t rd,
  output erc_pkg::row_t    rd_row
);
  import erc_pkg::*;

  row_t             mem [COUNTERS];
  logic [COUNTERS-1:0] vld_r;
  row_t             rd_row_r;
  logic             rd_vld_r;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd.en) begin
      rd_row_r <= mem[rd.addr];
    end
  end

  // Row valid bits; a row that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_row_r : '0;

endmodule

// ===== sv/erc_div.sv =====
// Restoring divider for the average: 64-bit total over 32-bit seconds.
// One quotient bit per cycle. Depends on erc_pkg.
module erc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [erc_pkg::TOT_W-1:0] dividend,
  input  logic [erc_pkg::SEC_W-1:0] divisor,
  output logic [erc_pkg::TOT_W-1:0] quotient,
  output erc_pkg::div_stat_t        stat
);
  import erc_pkg::*;

  logic [TOT_W-1:0]      quo_r, quo_nxt;
  logic [SEC_W-1:0]      rem_r, rem_nxt;
  logic [SEC_W-1:0]      dvs_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic                  busy_r, done_r;
  logic [SEC_W:0]        rem_sh;
  logic [SEC_W:0]        rem_sub;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh  = {rem_r, quo_r[TOT_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sub[SEC_W-1:0];
      quo_nxt = {quo_r[TOT_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[SEC_W-1:0];
      quo_nxt = {quo_r[TOT_W-2:0], 1'b0};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_STEP_W'(TOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // A new division never starts on top of one in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  // Done follows the last step of a busy run.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");
  // The divisor is never zero once a division is running.
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dvs_r != '0) else $error("divider running with zero divisor");

endmodule

// ===== sv/event_rate_counter_bank_top.sv =====
// Event rate counter bank: top level with sequencer, configuration register
// and output register. Depends on erc_pkg, erc_if, erc_row_mem and erc_div.
//
// Usage:
//   in_ch carries items (action, counter_index) on a valid/ready handshake.
//   Count and tick items give no result; a query item gives one result item
//   on out_ch (last second count, total, average, bad index flag).
//   The APB port holds counters_in_use at byte address 0 (reset 64).
// Sequence:
//   Count item: one memory read, one memory write of the row.
//   Tick item: a read and a write per row, over every row in turn,
//   through the single memory port pair.
//   Query item: result to the output register, after the bit-serial divider
//   when the index is valid and at least one second has passed.
//   in_ch.ready is high only while the sequencer is idle.
// Reset: synchronous, active low; the seconds count is cleared, and all counts
//   and totals read as zero afterwards through per-row valid bits, no clearing pass.
// Stall: a result waits in the output register; further count and tick
//   items proceed, and a later query holds until that result is taken.
module event_rate_counter_bank_top (
  input  logic                       clk,
  input  logic                       rst_n,
  erc_in_if.sink                     in_ch,
  erc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [erc_pkg::CFG_AW-1:0] paddr,
  input  logic [erc_pkg::CFG_DW-1:0] pwdata,
  output logic [erc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import erc_pkg::*;

  state_t            state_r, state_nxt;
  action_t           act_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_AW-1:0] sweep_r;
  logic [SEC_W-1:0]  elapsed_r;
  logic [CIU_W-1:0]  ciu_r;

  logic [RUN_W-1:0]  res_last_r;
  logic [TOT_W-1:0]  res_total_r;
  logic [TOT_W-1:0]  res_avg_r;
  logic              res_bad_r;

  logic              out_valid_r;
  logic [RUN_W-1:0]  out_last_r;
  logic [TOT_W-1:0]  out_total_r;
  logic [TOT_W-1:0]  out_avg_r;
  logic              out_bad_r;

  mem_wr_t           wr;
  mem_rd_t           rd;
  row_t              rd_row;
  logic              div_start;
  logic [TOT_W-1:0]  div_quo;
  div_stat_t         div_stat;

  logic              accept;
  logic              idx_ok;
  logic              idx_in_bank;
  logic              sweep_last;
  logic              out_load;
  logic              cfg_wr;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_sat;
  logic [RUN_W-1:0]  run_inc;

  erc_row_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd     (rd),
    .rd_row (rd_row)
  );

  erc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_row.total),
    .divisor  (elapsed_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Handshake and decode helpers.
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_in_bank = int'(idx_r) < COUNTERS;
  assign idx_ok      = idx_in_bank && ({1'b0, idx_r} < ciu_r);
  assign sweep_last  = sweep_r == CNT_AW'(COUNTERS - 1);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Saturating increment and saturating total update.
  assign run_inc = (rd_row.running == '1) ? rd_row.running : rd_row.running + 1'b1;
  assign tot_sum = {1'b0, rd_row.total} + {{(TOT_W-RUN_W+1){1'b0}}, rd_row.running};
  assign tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (act_r)
          ACT_COUNT: state_nxt = S_IDLE;
          ACT_TICK:  state_nxt = S_TRD;
          ACT_QUERY: state_nxt = (idx_ok && elapsed_r != '0) ? S_DIV : S_OUT;
          ACT_NONE:  state_nxt = S_IDLE;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_TRD:  state_nxt = S_TWR;
      S_TWR:  state_nxt = sweep_last ? S_IDLE : S_TRD;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory requests and divider start.
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    rd.en       = 1'b0;
    rd.addr     = CNT_AW'(in_ch.counter_index);
    wr.en       = 1'b0;
    wr.addr     = CNT_AW'(idx_r);
    wr.row      = rd_row;
    div_start   = 1'b0;
    unique case (state_r)
      S_IDLE: rd.en = accept;
      S_EXEC: begin
        if (act_r == ACT_COUNT && idx_in_bank) begin
          wr.en          = 1'b1;
          wr.row.running = run_inc;
        end
        div_start = (act_r == ACT_QUERY) && idx_ok && (elapsed_r != '0);
      end
      S_TRD: begin
        rd.en   = 1'b1;
        rd.addr = sweep_r;
      end
      S_TWR: begin
        wr.en          = 1'b1;
        wr.addr        = sweep_r;
        wr.row.running = '0;
        wr.row.last    = rd_row.running;
        wr.row.total   = tot_sat;
      end
      S_DIV, S_OUT: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elapsed_r   <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        sweep_r <= '0;
      end else if (state_r == S_TWR) begin
        sweep_r <= sweep_r + 1'b1;
        if (sweep_last && elapsed_r != '1) begin
          elapsed_r <= elapsed_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action_t'(in_ch.action);
      idx_r <= in_ch.counter_index;
    end
    if (state_r == S_EXEC) begin
      res_bad_r   <= !idx_ok;
      res_last_r  <= idx_ok ? rd_row.last : '0;
      res_total_r <= idx_ok ? rd_row.total : '0;
      res_avg_r   <= '0;
    end else if (state_r == S_DIV && div_stat.done) begin
      res_avg_r <= div_quo;
    end
    if (out_load) begin
      out_last_r  <= res_last_r;
      out_total_r <= res_total_r;
      out_avg_r   <= res_avg_r;
      out_bad_r   <= res_bad_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.last_second_count = out_last_r;
  assign out_ch.total_count       = out_total_r;
  assign out_ch.avg_per_sec       = out_avg_r;
  assign out_ch.bad_index         = out_bad_r;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COUNTERS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r <= CIU_RESET;
    end else if (cfg_wr) begin
      ciu_r <= pwdata[CIU_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COUNTERS_IN_USE) ?
                  {{(CFG_DW-CIU_W){1'b0}}, ciu_r} : '0;

  // A division starts only when at least one second has passed.
  a_div_needs_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> elapsed_r != '0) else $error("division started with zero seconds");
  // A bad index result carries zero counts.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |->
      (out_last_r == '0 && out_total_r == '0 && out_avg_r == '0))
    else $error("bad index result with nonzero fields");
  // The seconds count never goes down.
  a_seconds_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWR) |=> elapsed_r >= $past(elapsed_r))
    else $error("seconds count decreased");
  // No memory write is issued while a query waits on the divider.
  a_no_write_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !wr.en) else $error("memory write during division");

endmodule

// ===== dv/tb_event_rate_counter_bank_top.sv =====
// Self-checking testbench for the event rate counter bank top level.
// Depends on erc_pkg, erc_if and the top level; drives items, queries and register
// writes under random idling and predicts every query answer in the bench.
`timescale 1ns / 1ps

module tb_event_rate_counter_bank_top;
  import erc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 200;

  // One expected answer to a query.
  typedef struct {
    logic [RUN_W-1:0] last_second_count;
    logic [TOT_W-1:0] total_count;
    logic [TOT_W-1:0] avg_per_sec;
    logic             bad_index;
  } rate_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  erc_in_if in_ch ();
  erc_out_if out_ch ();

  event_rate_counter_bank_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Bench copy of the counter bank.
  logic [RUN_W-1:0] running_cnt [COUNTERS];
  logic [RUN_W-1:0] last_sec_cnt [COUNTERS];
  logic [TOT_W-1:0] total_cnt [COUNTERS];
  logic [SEC_W-1:0] seconds_seen;
  logic [CIU_W-1:0] in_use;

  rate_answer_t pending_answers[$];
  int errors = 0;
  int items_sent = 0;
  int answers_checked = 0;
  int ticks_sent = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;

  // Apply one accepted item to the bench copy and queue any answer it causes.
  task automatic predict_item(action_t act, logic [IDX_W-1:0] idx);
    rate_answer_t ans;
    logic [TOT_W-1:0] sum;
    case (act)
      ACT_COUNT: begin
        if (running_cnt[idx] != '1) running_cnt[idx]++;
      end
      ACT_TICK: begin
        for (int i = 0; i < COUNTERS; i++) begin
          sum = total_cnt[i] + TOT_W'(running_cnt[i]);
          total_cnt[i] = (sum < total_cnt[i]) ? '1 : sum;
          last_sec_cnt[i] = running_cnt[i];
          running_cnt[i] = '0;
        end
        if (seconds_seen != '1) seconds_seen++;
      end
      ACT_QUERY: begin
        if (int'(idx) >= COUNTERS || int'(idx) >= int'(in_use)) begin
          ans = '{'0, '0, '0, 1'b1};
        end else begin
          ans.last_second_count = last_sec_cnt[idx];
          ans.total_count = total_cnt[idx];
          ans.avg_per_sec = (seconds_seen == 0) ? '0 :
                            total_cnt[idx] / TOT_W'(seconds_seen);
          ans.bad_index = 1'b0;
        end
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // Offer one item, with random sender gaps, and wait for acceptance.
  task automatic send_item(action_t act, logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.counter_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(act, idx);
    items_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  // Lower valid and wait until the block is idle with nothing outstanding.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (addr == CFG_AW'(4 * REG_COUNTERS_IN_USE)) in_use = data[CIU_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Receiver ready: long hold-offs first, then random stalls.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare each accepted answer with the oldest expectation.
  always @(posedge clk) begin
    rate_answer_t exp_ans;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer with no query outstanding");
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        answers_checked++;
        if (out_ch.last_second_count !== exp_ans.last_second_count) begin
          $error("last_second_count: expected %0d, got %0d",
                 exp_ans.last_second_count, out_ch.last_second_count);
          errors++;
        end
        if (out_ch.total_count !== exp_ans.total_count) begin
          $error("total_count: expected %0d, got %0d",
                 exp_ans.total_count, out_ch.total_count);
          errors++;
        end
        if (out_ch.avg_per_sec !== exp_ans.avg_per_sec) begin
          $error("avg_per_sec: expected %0d, got %0d",
                 exp_ans.avg_per_sec, out_ch.avg_per_sec);
          errors++;
        end
        if (out_ch.bad_index !== exp_ans.bad_index) begin
          $error("bad_index: expected %0b, got %0b",
                 exp_ans.bad_index, out_ch.bad_index);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Edges of the index range, before and after the first tick, and action 3.
  task automatic test_directed();
    send_item(ACT_QUERY, 6'd0);
    send_item(ACT_COUNT, 6'd0);
    send_item(ACT_COUNT, 6'd63);
    send_item(ACT_COUNT, 6'd63);
    send_item(ACT_QUERY, 6'd63);
    send_item(ACT_TICK, 6'd17);
    send_item(ACT_QUERY, 6'd63);
    send_item(ACT_QUERY, 6'd0);
    send_item(ACT_NONE, 6'd63);
    send_item(ACT_COUNT, 6'd42);
    send_item(ACT_COUNT, 6'd21);
    send_item(ACT_TICK, 6'd0);
    send_item(ACT_QUERY, 6'd42);
    send_item(ACT_QUERY, 6'd21);
    send_item(ACT_QUERY, 6'd63);
    send_item(ACT_TICK, 6'd63);
    send_item(ACT_QUERY, 6'd63);
    drain();
  endtask

  // Counter limit settings, including zero, the bank size and above it.
  task automatic test_counters_in_use();
    logic [CFG_DW-1:0] limits [6] = '{0, 1, 63, 64, 127, 100};
    foreach (limits[k]) begin
      write_reg(CFG_AW'(4 * REG_COUNTERS_IN_USE), limits[k]);
      send_item(ACT_QUERY, 6'd0);
      send_item(ACT_QUERY, 6'd1);
      send_item(ACT_QUERY, 6'd62);
      send_item(ACT_QUERY, 6'd63);
      drain();
    end
    // A write outside the register map leaves the limit alone.
    write_reg(CFG_AW'(4), 32'd5);
    send_item(ACT_QUERY, 6'd10);
    drain();
  endtask

  // Mostly bursts of counts with queries, some ticks and a little action 3.
  task automatic test_random_traffic(int n_items);
    int pick;
    int base;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      base = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
      if (pick < 68) send_item(ACT_COUNT, IDX_W'(base));
      else if (pick < 72) send_item(ACT_TICK, IDX_W'($urandom_range(63)));
      else if (pick < 96) send_item(ACT_QUERY, IDX_W'($urandom_range(63)));
      else send_item(ACT_NONE, IDX_W'($urandom_range(63)));
    end
    drain();
  endtask

  // Hold the receiver off while queries keep coming, so the input stalls.
  task automatic test_backpressure();
    @(negedge clk);
    hold_off_cycles = 600;
    for (int i = 0; i < 12; i++) begin
      send_item(ACT_COUNT, IDX_W'(i));
      send_item(ACT_QUERY, IDX_W'($urandom_range(63)));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NONE;
    in_ch.counter_index = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < COUNTERS; i++) begin
      running_cnt[i] = '0;
      last_sec_cnt[i] = '0;
      total_cnt[i] = '0;
    end
    seconds_seen = '0;
    in_use = CIU_RESET;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_counters_in_use();
    write_reg(CFG_AW'(4 * REG_COUNTERS_IN_USE), 32'd64);

    // Idling phases: none, sender gaps, receiver stalls, both light.
    sender_gap_pct = 0;  receiver_stall_pct = 0;
    test_random_traffic(380);
    write_reg(CFG_AW'(4 * REG_COUNTERS_IN_USE), 32'($urandom_range(40, 64)));
    sender_gap_pct = 53; receiver_stall_pct = 0;
    test_random_traffic(380);
    write_reg(CFG_AW'(4 * REG_COUNTERS_IN_USE), 32'($urandom_range(0, 127)));
    sender_gap_pct = 0;  receiver_stall_pct = 53;
    test_random_traffic(380);
    test_backpressure();
    write_reg(CFG_AW'(4 * REG_COUNTERS_IN_USE), 32'd127);
    sender_gap_pct = 12; receiver_stall_pct = 12;
    test_random_traffic(380);

    $display("Sent %0d items (%0d ticks), checked %0d query answers,", items_sent,
             ticks_sent, answers_checked);
    $display("over four idling phases and several counter limits.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
